>>> rtl/dss_pkg.sv
`timescale 1ns / 1ps

package dss_pkg;

	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 64;

	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int CNT_W   = $clog2(CAPACITY + 1);

	// fixed field widths of the request and response
	localparam int OP_W    = 3;
	localparam int KEY_W   = 64;
	localparam int POS_W   = 7;
	localparam int STAT_W  = 3;
	localparam int SLOT_W  = 6;
	localparam int COUNT_W = 7;

	localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

	localparam logic [OP_W-1:0] OP_INSERT  = 3'd0;
	localparam logic [OP_W-1:0] OP_FIND    = 3'd1;
	localparam logic [OP_W-1:0] OP_READ    = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_POS = 3'd3;
	localparam logic [OP_W-1:0] OP_DEL_VAL = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_DUP      = 3'd1;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
	localparam logic [STAT_W-1:0] ST_RANGE    = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [KEY_W-1:0] key_value;
		logic [POS_W-1:0] position;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [KEY_W-1:0]   read_value;
		logic [SLOT_W-1:0]  found_slot;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic                   we;
		logic [IDX_W-1:0]       waddr;
		logic [VALUE_WIDTH-1:0] wdata;
		logic                   re;
		logic [IDX_W-1:0]       raddr;
	} mem_req_t;

endpackage

>>> rtl/dss_ram.sv
`timescale 1ns / 1ps

// simple dual-port RAM, registered read
module dss_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/dss_ctrl.sv
`timescale 1ns / 1ps

// sequencer: scan, shift-down delete, response register
module dss_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  dss_pkg::req_t                   req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output dss_pkg::rsp_t                   rsp,
	output dss_pkg::mem_req_t               mem,
	input  logic [dss_pkg::VALUE_WIDTH-1:0] rdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISP,
		S_SCAN,
		S_RDW,
		S_SHIFT,
		S_RESP
	} state_t;

	state_t                          state_q;
	logic [dss_pkg::OP_W-1:0]        op_q;
	logic [dss_pkg::VALUE_WIDTH-1:0] key_q;
	logic [dss_pkg::POS_W-1:0]       pos_q;
	logic [dss_pkg::CNT_W-1:0]       cnt_q;
	logic [dss_pkg::CNT_W-1:0]       ptr_q;
	logic                            chk_s1;
	logic [dss_pkg::IDX_W-1:0]       chk_slot_s1;
	logic [dss_pkg::STAT_W-1:0]      res_status_q;
	logic [dss_pkg::VALUE_WIDTH-1:0] res_value_q;
	logic [dss_pkg::IDX_W-1:0]       res_slot_q;
	logic                            out_valid_q;
	dss_pkg::rsp_t                   out_q;

	logic                      hit;
	logic                      scan_end;
	logic [dss_pkg::CMP_W-1:0] pos_ext;
	logic [dss_pkg::CMP_W-1:0] cnt_ext;
	logic                      pos_bad;
	logic [dss_pkg::IDX_W-1:0] pos_slot;

	assign hit      = chk_s1 && (rdata == key_q);
	assign scan_end = (ptr_q >= cnt_q);
	assign pos_ext  = dss_pkg::CMP_W'(pos_q);
	assign cnt_ext  = dss_pkg::CMP_W'(cnt_q);
	assign pos_bad  = (pos_ext == '0) || (pos_ext > cnt_ext);
	assign pos_slot = dss_pkg::IDX_W'(pos_ext - dss_pkg::CMP_W'(1));

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_comb begin
		mem = '0;
		case (state_q)
			S_DISP: begin
				if (op_q == dss_pkg::OP_READ && !pos_bad) begin
					mem.re    = 1'b1;
					mem.raddr = pos_slot;
				end
			end
			S_SCAN: begin
				if (!hit && !scan_end) begin
					mem.re    = 1'b1;
					mem.raddr = ptr_q[dss_pkg::IDX_W-1:0];
				end
				// append on a miss while room remains
				if (!hit && scan_end && op_q == dss_pkg::OP_INSERT &&
				    cnt_q < dss_pkg::CNT_W'(dss_pkg::CAPACITY)) begin
					mem.we    = 1'b1;
					mem.waddr = cnt_q[dss_pkg::IDX_W-1:0];
					mem.wdata = key_q;
				end
			end
			S_SHIFT: begin
				if (!scan_end) begin
					mem.re    = 1'b1;
					mem.raddr = ptr_q[dss_pkg::IDX_W-1:0];
				end
				// entry read last cycle moves down one slot
				if (chk_s1) begin
					mem.we    = 1'b1;
					mem.waddr = chk_slot_s1 - dss_pkg::IDX_W'(1);
					mem.wdata = rdata;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= '0;
			key_q        <= '0;
			pos_q        <= '0;
			cnt_q        <= '0;
			ptr_q        <= '0;
			chk_s1       <= 1'b0;
			chk_slot_s1  <= '0;
			res_status_q <= dss_pkg::ST_OK;
			res_value_q  <= '0;
			res_slot_q   <= '0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
		end else begin
			// S_RESP reloads the output register itself
			if (out_valid_q && !rsp_stall && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						op_q         <= req.operation;
						key_q        <= req.key_value[dss_pkg::VALUE_WIDTH-1:0];
						pos_q        <= req.position;
						res_status_q <= dss_pkg::ST_OK;
						res_value_q  <= '0;
						res_slot_q   <= '0;
						state_q      <= S_DISP;
					end
				end
				S_DISP: begin
					chk_s1 <= 1'b0;
					case (op_q)
						dss_pkg::OP_INSERT, dss_pkg::OP_FIND, dss_pkg::OP_DEL_VAL: begin
							ptr_q   <= '0;
							state_q <= S_SCAN;
						end
						dss_pkg::OP_READ: begin
							if (pos_bad) begin
								res_status_q <= dss_pkg::ST_RANGE;
								state_q      <= S_RESP;
							end else begin
								state_q <= S_RDW;
							end
						end
						dss_pkg::OP_DEL_POS: begin
							if (pos_bad) begin
								res_status_q <= dss_pkg::ST_RANGE;
								state_q      <= S_RESP;
							end else begin
								// first entry to move sits at 0-based slot pos
								ptr_q   <= dss_pkg::CNT_W'(pos_ext);
								state_q <= S_SHIFT;
							end
						end
						default: begin
							res_status_q <= dss_pkg::ST_RANGE;
							state_q      <= S_RESP;
						end
					endcase
				end
				S_SCAN: begin
					if (hit) begin
						res_slot_q <= chk_slot_s1;
						chk_s1     <= 1'b0;
						case (op_q)
							dss_pkg::OP_INSERT: begin
								res_status_q <= dss_pkg::ST_DUP;
								state_q      <= S_RESP;
							end
							dss_pkg::OP_DEL_VAL: begin
								ptr_q   <= dss_pkg::CNT_W'(chk_slot_s1) + dss_pkg::CNT_W'(1);
								state_q <= S_SHIFT;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end else if (scan_end) begin
						chk_s1 <= 1'b0;
						if (op_q == dss_pkg::OP_INSERT) begin
							if (cnt_q < dss_pkg::CNT_W'(dss_pkg::CAPACITY)) begin
								cnt_q <= cnt_q + dss_pkg::CNT_W'(1);
							end else begin
								res_status_q <= dss_pkg::ST_FULL;
							end
						end else begin
							res_status_q <= dss_pkg::ST_NOTFOUND;
						end
						state_q <= S_RESP;
					end else begin
						chk_s1      <= 1'b1;
						chk_slot_s1 <= ptr_q[dss_pkg::IDX_W-1:0];
						ptr_q       <= ptr_q + dss_pkg::CNT_W'(1);
					end
				end
				S_RDW: begin
					res_value_q <= rdata;
					state_q     <= S_RESP;
				end
				S_SHIFT: begin
					if (!scan_end) begin
						chk_s1      <= 1'b1;
						chk_slot_s1 <= ptr_q[dss_pkg::IDX_W-1:0];
						ptr_q       <= ptr_q + dss_pkg::CNT_W'(1);
					end else begin
						chk_s1  <= 1'b0;
						cnt_q   <= cnt_q - dss_pkg::CNT_W'(1);
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!out_valid_q || !rsp_stall) begin
						out_q.status      <= res_status_q;
						out_q.read_value  <= dss_pkg::KEY_W'(res_value_q);
						out_q.found_slot  <= dss_pkg::SLOT_W'(res_slot_q);
						out_q.entry_count <= dss_pkg::COUNT_W'(cnt_q);
						out_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/dedup_set_store_core.sv
`timescale 1ns / 1ps

// Set store: a packed table of distinct values, searched linearly.
// Request channel (req_valid / req_stall / req) carries operation, key_value
// and position; a request is taken on a clock edge with req_valid high and
// req_stall low. Response channel (rsp_valid / rsp_stall / rsp) returns one
// response per request: status, read_value, found_slot, entry_count.
// Search and shift-down work goes through the single read port of the value
// RAM: one entry is read per cycle during a search or a shift-down, a search
// runs from slot 0 to a hit or to the count, and delete by value scans, then
// shifts the entries above the hit down; one request is in flight at a time.
// req_stall is high whenever a request is being worked on. A finished
// response sits in an output register, so the next request is taken while
// a response is still stalled; a later response waits until it drains.
// Reset clears the entry count and the handshake state; the value RAM is
// not cleared, entries at or above the count are never read.
module dedup_set_store_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  dss_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dss_pkg::rsp_t rsp
);

	dss_pkg::mem_req_t               mem;
	logic [dss_pkg::VALUE_WIDTH-1:0] rdata;

	// sequencer: owns the count, the scan pointer and the response register
	dss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.mem       (mem),
		.rdata     (rdata)
	);

	// value table, one write and one registered read per cycle
	dss_ram #(
		.DEPTH (dss_pkg::CAPACITY),
		.WIDTH (dss_pkg::VALUE_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.re    (mem.re),
		.raddr (mem.raddr),
		.rdata (rdata)
	);

endmodule

>>> sim/dedup_set_store_core_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the set store core.
// A local model of the table (packed entries in insertion order, plus the live
// count) predicts the response of every request when the core takes it. The
// expected responses wait in a FIFO, and the checker compares each response
// the core hands out against the oldest one, field by field.
// Stimulus runs in this order:
//   - hand-picked cases: empty table, range errors, duplicates, unused opcodes,
//     delete with shift-down
//   - filling the table to capacity and probing the full condition
//   - random traffic in three phases with different idle patterns; after the
//     first, a long response hold-off backs the core up into its request side
module dedup_set_store_core_tb;

	localparam logic [dss_pkg::OP_W-1:0]  OP_UNUSED_FIRST = 3'd5;
	localparam logic [dss_pkg::OP_W-1:0]  OP_UNUSED_LAST  = 3'd7;
	localparam logic [dss_pkg::KEY_W-1:0] KEY_ONES        = {dss_pkg::KEY_W{1'b1}};
	localparam logic [dss_pkg::KEY_W-1:0] KEY_MSB         =
		{1'b1, {(dss_pkg::KEY_W-1){1'b0}}};
	localparam logic [dss_pkg::POS_W-1:0] POS_MAX         = {dss_pkg::POS_W{1'b1}};
	localparam int                        DRAIN_CYCLES    = 2 * dss_pkg::CAPACITY + 20;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_stall;
	dss_pkg::req_t  req       = '0;
	logic           rsp_valid;
	logic           rsp_stall = 1'b0;
	dss_pkg::rsp_t  rsp;

	// model of the table contents
	logic [dss_pkg::VALUE_WIDTH-1:0] tbl [dss_pkg::CAPACITY];
	int                              tbl_count = 0;

	dss_pkg::rsp_t  pending_rsp [$];
	dss_pkg::rsp_t  want;
	int             mismatch_count = 0;

	// idle percentages for the two sides
	int    tx_idle_pct = 0;
	int    rx_idle_pct = 0;

	// long hold-off order: the test posts a length and bumps the tag
	int    hold_cycles   = 0;
	int    hold_tag      = 0;
	int    hold_tag_seen = 0;
	int    hold_left     = 0;

	dedup_set_store_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Removes one entry and closes the gap, like the core's shift-down.
	function automatic void drop_entry(input int s);
		for (int i = s + 1; i < tbl_count; i++)
			tbl[i-1] = tbl[i];
		tbl_count--;
	endfunction

	// Applies one request to the table model and returns its response.
	function automatic dss_pkg::rsp_t apply_request(input dss_pkg::req_t r);
		dss_pkg::rsp_t o;
		int   hit;
		int   pos;
		logic [dss_pkg::VALUE_WIDTH-1:0] key;
		o   = '0;
		hit = -1;
		pos = int'(r.position);
		key = r.key_value[dss_pkg::VALUE_WIDTH-1:0];
		// first matching slot; only used by value-based operations
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl[i] == key) begin
				hit = i;
				break;
			end
		end
		o.status = dss_pkg::ST_OK;
		case (r.operation)
			dss_pkg::OP_INSERT: begin
				if (hit >= 0) begin
					o.status     = dss_pkg::ST_DUP;
					o.found_slot = dss_pkg::SLOT_W'(hit);
				end else if (tbl_count >= dss_pkg::CAPACITY) begin
					o.status = dss_pkg::ST_FULL;
				end else begin
					tbl[tbl_count] = key;
					tbl_count++;
				end
			end
			dss_pkg::OP_FIND: begin
				if (hit >= 0)
					o.found_slot = dss_pkg::SLOT_W'(hit);
				else
					o.status = dss_pkg::ST_NOTFOUND;
			end
			dss_pkg::OP_READ: begin
				if (pos == 0 || pos > tbl_count)
					o.status = dss_pkg::ST_RANGE;
				else
					o.read_value = dss_pkg::KEY_W'(tbl[pos-1]);
			end
			dss_pkg::OP_DEL_POS: begin
				if (pos == 0 || pos > tbl_count)
					o.status = dss_pkg::ST_RANGE;
				else
					drop_entry(pos - 1);
			end
			dss_pkg::OP_DEL_VAL: begin
				if (hit >= 0) begin
					o.found_slot = dss_pkg::SLOT_W'(hit);
					drop_entry(hit);
				end else begin
					o.status = dss_pkg::ST_NOTFOUND;
				end
			end
			default: o.status = dss_pkg::ST_RANGE;
		endcase
		o.entry_count = dss_pkg::COUNT_W'(tbl_count);
		return o;
	endfunction

	// Offers one request and holds it until taken. Valid stays high into the
	// next request unless the sender decides to idle.
	task automatic send_request(input logic [dss_pkg::OP_W-1:0] op,
			input logic [dss_pkg::KEY_W-1:0] key, input logic [dss_pkg::POS_W-1:0] pos);
		dss_pkg::req_t r;
		r.operation = op;
		r.key_value = key;
		r.position  = pos;
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_rsp.push_back(apply_request(r));
		if ($urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	// Key mix: live entries for hits, bit-pattern corners, and fully random.
	function automatic logic [dss_pkg::KEY_W-1:0] pick_key();
		int roll;
		roll = $urandom_range(99);
		if (roll < 45 && tbl_count > 0)
			return dss_pkg::KEY_W'(tbl[$urandom_range(0, tbl_count - 1)]);
		if (roll < 60) begin
			case ($urandom_range(0, 5))
				0: return '0;
				1: return KEY_ONES;
				2: return KEY_MSB;
				3: return dss_pkg::KEY_W'(1);
				4: return {(dss_pkg::KEY_W/2){2'b01}};
				default: return {(dss_pkg::KEY_W/2){2'b10}};
			endcase
		end
		return {$urandom, $urandom};
	endfunction

	// Mostly valid 1-based positions, some just past the end, some anywhere.
	function automatic logic [dss_pkg::POS_W-1:0] pick_position();
		int roll;
		roll = $urandom_range(99);
		if (roll < 80 && tbl_count > 0)
			return dss_pkg::POS_W'($urandom_range(1, tbl_count));
		if (roll < 90)
			return dss_pkg::POS_W'($urandom_range(0, tbl_count + 1));
		return dss_pkg::POS_W'($urandom_range(0, int'(POS_MAX)));
	endfunction

	task automatic send_random_request();
		logic [dss_pkg::OP_W-1:0] op;
		int roll;
		int ins_weight;
		roll       = $urandom_range(99);
		// back off inserts near capacity so the count keeps moving
		ins_weight = (tbl_count < dss_pkg::CAPACITY - 8) ? 40 : 15;
		if (roll < 3)
			op = dss_pkg::OP_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
		else if (roll < 3 + ins_weight)
			op = dss_pkg::OP_INSERT;
		else begin
			case ($urandom_range(0, 3))
				0: op = dss_pkg::OP_FIND;
				1: op = dss_pkg::OP_READ;
				2: op = dss_pkg::OP_DEL_POS;
				default: op = dss_pkg::OP_DEL_VAL;
			endcase
		end
		send_request(op, pick_key(), pick_position());
	endtask

	// Empty table, range errors, duplicates, unused opcodes and shift-down.
	task automatic test_directed_cases();
		send_request(dss_pkg::OP_FIND, '0, '0);
		send_request(dss_pkg::OP_READ, '0, '0);
		send_request(dss_pkg::OP_READ, '0, dss_pkg::POS_W'(1));
		send_request(dss_pkg::OP_DEL_POS, '0, dss_pkg::POS_W'(1));
		send_request(dss_pkg::OP_DEL_VAL, '0, '0);
		send_request(dss_pkg::OP_INSERT, '0, '0);
		send_request(dss_pkg::OP_INSERT, KEY_ONES, POS_MAX);
		send_request(dss_pkg::OP_INSERT, '0, '0);
		send_request(dss_pkg::OP_INSERT, KEY_ONES, '0);
		send_request(dss_pkg::OP_FIND, KEY_ONES, '0);
		send_request(dss_pkg::OP_READ, '0, dss_pkg::POS_W'(1));
		send_request(dss_pkg::OP_READ, '0, dss_pkg::POS_W'(2));
		send_request(dss_pkg::OP_READ, '0, dss_pkg::POS_W'(3));
		send_request(dss_pkg::OP_READ, KEY_ONES, POS_MAX);
		for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
			send_request(dss_pkg::OP_W'(op), KEY_ONES, dss_pkg::POS_W'(1));
		send_request(dss_pkg::OP_INSERT, KEY_MSB, '0);
		// drop the middle entry; the last one moves down
		send_request(dss_pkg::OP_DEL_POS, '0, dss_pkg::POS_W'(2));
		send_request(dss_pkg::OP_READ, '0, dss_pkg::POS_W'(2));
		send_request(dss_pkg::OP_DEL_VAL, '0, '0);
		send_request(dss_pkg::OP_FIND, KEY_MSB, '0);
		send_request(dss_pkg::OP_DEL_VAL, '0, '0);
		send_request(dss_pkg::OP_DEL_POS, '0, dss_pkg::POS_W'(1));
	endtask

	// Fill to capacity, then probe full, last slot and longest shift.
	task automatic test_full_table();
		logic [dss_pkg::KEY_W-1:0] last_key;
		while (tbl_count < dss_pkg::CAPACITY)
			send_request(dss_pkg::OP_INSERT, {$urandom, $urandom}, '0);
		last_key = dss_pkg::KEY_W'(tbl[dss_pkg::CAPACITY-1]);
		send_request(dss_pkg::OP_INSERT, ~last_key, '0);
		send_request(dss_pkg::OP_INSERT, last_key, '0);
		send_request(dss_pkg::OP_FIND, last_key, '0);
		send_request(dss_pkg::OP_READ, '0, dss_pkg::POS_W'(dss_pkg::CAPACITY));
		send_request(dss_pkg::OP_READ, '0, dss_pkg::POS_W'(dss_pkg::CAPACITY + 1));
		send_request(dss_pkg::OP_DEL_VAL, last_key, '0);
		send_request(dss_pkg::OP_INSERT, last_key, '0);
		send_request(dss_pkg::OP_DEL_POS, '0, dss_pkg::POS_W'(1));
		send_request(dss_pkg::OP_DEL_POS, '0, dss_pkg::POS_W'(dss_pkg::CAPACITY - 1));
		send_request(dss_pkg::OP_DEL_POS, '0, dss_pkg::POS_W'(dss_pkg::CAPACITY));
	endtask

	task automatic test_random_traffic(input int n_req, input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		repeat (n_req)
			send_random_request();
	endtask

	// Response side holds off for a long stretch while requests keep coming,
	// so the output register fills and the core stalls its request side.
	task automatic test_backpressure();
		tx_idle_pct = 0;
		hold_cycles = 400;
		hold_tag++;
		repeat (16)
			send_random_request();
	endtask

	// Response side: random stall, or a counted hold-off when one is posted.
	always @(posedge clk) begin
		if (hold_tag != hold_tag_seen) begin
			hold_tag_seen <= hold_tag;
			hold_left     <= hold_cycles;
			rsp_stall     <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	task automatic report_field(input string name, input logic [dss_pkg::KEY_W-1:0] exp_v,
			input logic [dss_pkg::KEY_W-1:0] got_v);
		if (exp_v !== got_v) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
			mismatch_count++;
		end
	endtask

	// Response checker: every taken response against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: response with none expected, got %p", $time, rsp);
				mismatch_count++;
			end else begin
				want = pending_rsp.pop_front();
				report_field("status", dss_pkg::KEY_W'(want.status),
					dss_pkg::KEY_W'(rsp.status));
				report_field("read_value", want.read_value, rsp.read_value);
				report_field("found_slot", dss_pkg::KEY_W'(want.found_slot),
					dss_pkg::KEY_W'(rsp.found_slot));
				report_field("entry_count", dss_pkg::KEY_W'(want.entry_count),
					dss_pkg::KEY_W'(rsp.entry_count));
			end
		end
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;

		tx_idle_pct = 29;
		rx_idle_pct = 58;
		test_directed_cases();
		test_full_table();

		test_random_traffic(210, 29, 58);
		test_backpressure();
		test_random_traffic(210, 58, 29);
		test_random_traffic(210, 0, 0);

		// stop offering, then let the last responses out
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (mismatch_count == 0 && pending_rsp.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
